@@ rtl/core/pva_pkg.sv @@
package pva_pkg;

   // Command codes of the request channel.
   localparam logic [2:0] CMD_START        = 3'd0;
   localparam logic [2:0] CMD_STOP_SOURCE  = 3'd1;
   localparam logic [2:0] CMD_STOP_CHANNEL = 3'd2;
   localparam logic [2:0] CMD_SET_PRIORITY = 3'd3;
   localparam logic [2:0] CMD_STOP_ALL     = 3'd4;

   // Status codes of the response channel.
   localparam logic [1:0] STAT_DONE      = 2'd0;
   localparam logic [1:0] STAT_REJECTED  = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [1:0] STAT_IGNORED   = 2'd3;

   // Register file: word index taken from the byte address.
   localparam int         CSR_ADDR_W          = 3;
   localparam logic       REG_CHANNELS_IN_USE = 1'b0;
   localparam logic       REG_EFFECTS_ENABLED = 1'b1;
   localparam logic [5:0] CHANNELS_RESET      = 6'd8;
   localparam logic       EFFECTS_RESET       = 1'b1;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] source_id;
      logic [3:0]  sound_class;
      logic [7:0]  request_priority;
      logic [4:0]  channel_sel;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] channel;
      logic       stopped_playing;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_COMMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_IGNORE,
      OP_SCAN,
      OP_DIRECT
   } op_kind_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_step;
      logic commit;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      op_kind_type kind;
      logic        scan_done;
   } dp_status_type;

endpackage

@@ rtl/core/pva_ram.sv @@
module pva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic [ADDR_W-1:0]      rd_addr,
   output logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/pva_ctrl.sv @@
module pva_ctrl
   import pva_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type dp_status,
   output logic          busy,
   output ctl_cmd_type   ctl_cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (dp_status.kind == OP_SCAN) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_SCAN: begin
            if (dp_status.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      ctl_cmd = '0;
      busy    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy         = 1'b0;
            ctl_cmd.load = start;
         end
         S_DECODE: begin
            ctl_cmd.scan_init = 1'b1;
         end
         S_SCAN: begin
            ctl_cmd.scan_step = 1'b1;
         end
         S_COMMIT: begin
            ctl_cmd.commit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ rtl/core/pva_datapath.sv @@
module pva_datapath
   import pva_pkg::*;
#(
   parameter int NUM_VOICES = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   ctl_cmd,
   input  req_type       req_data,
   input  logic [5:0]    cfg_channels,
   input  logic          cfg_enabled,
   output dp_status_type dp_status,
   output logic          rsp_strobe,
   output rsp_type       rsp_data
);

   localparam int AW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CW = $clog2(NUM_VOICES + 1);

   req_type             req_ff;
   logic [NUM_VOICES-1:0] busy_ff;
   logic [NUM_VOICES-1:0] busy_in;
   logic [CW-1:0]       addr_ff;
   logic                pipe_vld_ff;
   logic [AW-1:0]       pipe_idx_ff;
   logic                match_found_ff;
   logic [AW-1:0]       match_idx_ff;
   logic                free_found_ff;
   logic [AW-1:0]       free_idx_ff;
   logic                any_busy_ff;
   logic [7:0]          max_pri_ff;
   logic [AW-1:0]       max_idx_ff;
   logic                rsp_strobe_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic [CW-1:0]       n_active;
   logic                issue;
   logic [19:0]         rd_sc;
   logic [7:0]          rd_pri;
   logic                entry_busy;
   logic                src_eq;
   logic                cls_eq;
   logic                entry_match;
   logic [AW-1:0]       sel_idx;
   logic                sel_ok;
   logic [NUM_VOICES-1:0] in_use;
   logic                wr_sc_en;
   logic                wr_pri_en;
   logic [AW-1:0]       wr_addr;

   // Active channel count, clamped to the built depth.
   assign n_active = (32'(cfg_channels) > 32'(NUM_VOICES)) ? CW'(NUM_VOICES)
                                                           : CW'(cfg_channels);

   assign issue = addr_ff < n_active;

   // Classify the latched request and report the end of the scan.
   always_comb begin
      if (!cfg_enabled || req_ff.cmd > CMD_STOP_ALL) begin
         dp_status.kind = OP_IGNORE;
      end else if (req_ff.cmd == CMD_START || req_ff.cmd == CMD_STOP_SOURCE) begin
         dp_status.kind = OP_SCAN;
      end else begin
         dp_status.kind = OP_DIRECT;
      end
      dp_status.scan_done = !issue && !pipe_vld_ff;
   end

   // Compare the entry read in the previous cycle.
   assign entry_busy  = busy_ff[pipe_idx_ff];
   assign src_eq      = rd_sc[19:4] == req_ff.source_id;
   assign cls_eq      = rd_sc[3:0] == req_ff.sound_class;
   assign entry_match = entry_busy && src_eq && (cls_eq || req_ff.cmd == CMD_STOP_SOURCE);

   // Request latch.
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Scan pipeline: issue one read per cycle and evaluate it in the cycle after.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         pipe_vld_ff <= 1'b0;
      end else if (ctl_cmd.scan_init) begin
         addr_ff     <= '0;
         pipe_vld_ff <= 1'b0;
      end else if (ctl_cmd.scan_step) begin
         pipe_vld_ff <= issue;
         if (issue) begin
            addr_ff <= addr_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.scan_step) begin
         pipe_idx_ff <= addr_ff[AW-1:0];
      end
   end

   // Search results: first match, first free entry, first least important entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         any_busy_ff    <= 1'b0;
      end else if (ctl_cmd.scan_init) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         any_busy_ff    <= 1'b0;
      end else if (ctl_cmd.scan_step && pipe_vld_ff) begin
         if (entry_match && !match_found_ff) begin
            match_found_ff <= 1'b1;
         end
         if (!entry_busy && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
         if (entry_busy) begin
            any_busy_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.scan_step && pipe_vld_ff) begin
         if (entry_match && !match_found_ff) begin
            match_idx_ff <= pipe_idx_ff;
         end
         if (!entry_busy && !free_found_ff) begin
            free_idx_ff <= pipe_idx_ff;
         end
         if (entry_busy && (!any_busy_ff || rd_pri > max_pri_ff)) begin
            max_pri_ff <= rd_pri;
            max_idx_ff <= pipe_idx_ff;
         end
      end
   end

   // Selected channel for the direct commands.
   assign sel_idx = AW'(req_ff.channel_sel);
   assign sel_ok  = (32'(req_ff.channel_sel) < 32'(n_active)) && busy_ff[sel_idx];

   always_comb begin
      for (int i = 0; i < NUM_VOICES; i++) begin
         in_use[i] = CW'(i) < n_active;
      end
   end

   // Commit decision: response, busy bits and table writes.
   always_comb begin
      rsp_in    = '{status: STAT_IGNORED, channel: 5'd0, stopped_playing: 1'b0};
      busy_in   = busy_ff;
      wr_sc_en  = 1'b0;
      wr_pri_en = 1'b0;
      wr_addr   = sel_idx;
      if (dp_status.kind != OP_IGNORE) begin
         case (req_ff.cmd)
            CMD_START: begin
               if (match_found_ff) begin
                  wr_addr = match_idx_ff;
                  rsp_in  = '{STAT_DONE, 5'(match_idx_ff), 1'b1};
               end else if (free_found_ff) begin
                  wr_addr = free_idx_ff;
                  rsp_in  = '{STAT_DONE, 5'(free_idx_ff), 1'b0};
               end else begin
                  wr_addr = max_idx_ff;
                  rsp_in  = '{STAT_DONE, 5'(max_idx_ff), 1'b1};
               end
               if (!match_found_ff && !free_found_ff &&
                   (n_active == '0 || req_ff.request_priority > max_pri_ff)) begin
                  rsp_in = '{STAT_REJECTED, 5'd0, 1'b0};
               end else begin
                  wr_sc_en         = 1'b1;
                  wr_pri_en        = 1'b1;
                  busy_in[wr_addr] = 1'b1;
               end
            end
            CMD_STOP_SOURCE: begin
               if (match_found_ff) begin
                  busy_in[match_idx_ff] = 1'b0;
                  rsp_in = '{STAT_DONE, 5'(match_idx_ff), 1'b1};
               end else begin
                  rsp_in = '{STAT_NOT_FOUND, 5'd0, 1'b0};
               end
            end
            CMD_STOP_CHANNEL: begin
               if (sel_ok) begin
                  busy_in[sel_idx] = 1'b0;
                  rsp_in = '{STAT_DONE, req_ff.channel_sel, 1'b1};
               end else begin
                  rsp_in = '{STAT_NOT_FOUND, 5'd0, 1'b0};
               end
            end
            CMD_SET_PRIORITY: begin
               if (sel_ok) begin
                  wr_pri_en = 1'b1;
                  rsp_in    = '{STAT_DONE, req_ff.channel_sel, 1'b0};
               end else begin
                  rsp_in = '{STAT_NOT_FOUND, 5'd0, 1'b0};
               end
            end
            CMD_STOP_ALL: begin
               busy_in = busy_ff & ~in_use;
               rsp_in  = '{STAT_DONE, 5'd0, |(busy_ff & in_use)};
            end
            default: begin
               rsp_in = '{STAT_IGNORED, 5'd0, 1'b0};
            end
         endcase
      end
   end

   // Busy bits and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl_cmd.commit;
         if (ctl_cmd.commit) begin
            busy_ff <= busy_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Source and class table.
   pva_ram #(
      .WIDTH (20),
      .DEPTH (NUM_VOICES)
   ) u_src_ram (
      .clock   (clock),
      .wr_en   (ctl_cmd.commit && wr_sc_en),
      .wr_addr (wr_addr),
      .wr_data ({req_ff.source_id, req_ff.sound_class}),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_sc)
   );

   // Priority table.
   pva_ram #(
      .WIDTH (8),
      .DEPTH (NUM_VOICES)
   ) u_pri_ram (
      .clock   (clock),
      .wr_en   (ctl_cmd.commit && wr_pri_en),
      .wr_addr (wr_addr),
      .wr_data (req_ff.request_priority),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_pri)
   );

endmodule

@@ rtl/core/priority_voice_allocator.sv @@
// Flow: an enabled start or stop-by-source command answers after a scan over the
// active channel count; every other command answers without a scan.
// Throughput: one command at a time; the next is taken in the cycle its answer shows.
// Synchronous active-high reset empties all channels and restores the registers;
// the receiver cannot stall, so each answer is shown for exactly one cycle.
module priority_voice_allocator
   import pva_pkg::*;
#(
   parameter int NUM_VOICES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [5:0]    chan_in_use_ff;
   logic          effects_en_ff;
   logic          csr_write;
   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   // Register writes complete in the access phase.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_in_use_ff <= CHANNELS_RESET;
         effects_en_ff  <= EFFECTS_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_CHANNELS_IN_USE) begin
            chan_in_use_ff <= pwdata[5:0];
         end else begin
            effects_en_ff <= pwdata[0];
         end
      end
   end

   // Register read.
   assign prdata = (paddr[2] == REG_EFFECTS_ENABLED) ? {31'd0, effects_en_ff}
                                                     : {26'd0, chan_in_use_ff};

   pva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .busy      (busy),
      .ctl_cmd   (ctl_cmd)
   );

   pva_datapath #(
      .NUM_VOICES (NUM_VOICES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl_cmd      (ctl_cmd),
      .req_data     (req_data),
      .cfg_channels (chan_in_use_ff),
      .cfg_enabled  (effects_en_ff),
      .dp_status    (dp_status),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data)
   );

endmodule

@@ rtl/core/pva_checker.sv @@
module pva_checker
   import pva_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // An accepted command keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not make the block busy");

   // An answer is shown only once the block is free again.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("answer shown while the block is busy");

   // Answers never come in consecutive cycles.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("answer strobe held for more than one cycle");

   // Reset leaves the block idle with no answer pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

   // Ignored and rejected answers name no channel and stop nothing.
   a_no_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == STAT_IGNORED || rsp_data.status == STAT_REJECTED)
      |-> rsp_data.channel == 5'd0 && !rsp_data.stopped_playing)
      else $error("ignored or rejected answer carries a channel");

endmodule

bind priority_voice_allocator pva_checker u_pva_checker (.*);
